[sv/hrls_pkg.sv]
// ----------------------------------------------------------------------------
// hrls_pkg
// Shared constants for the request line splitter: character codes, field
// tags, line status codes, register indexes and capacity reset values.
// ----------------------------------------------------------------------------
package hrls_pkg;

  localparam int CAP_W         = 12;
  localparam int CFG_IDX_W     = 2;
  localparam int COUNT_WIDTH_D = 12;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  // Field tags carried with every word.
  localparam logic [1:0] TAG_SEP    = 2'd0;
  localparam logic [1:0] TAG_METHOD = 2'd1;
  localparam logic [1:0] TAG_PATH   = 2'd2;
  localparam logic [1:0] TAG_QUERY  = 2'd3;

  // Line status, meaningful when line_done is set.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_OK_QUERY = 2'd1;
  localparam logic [1:0] STAT_ERROR    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_METHOD_CAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATH_CAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_CAP  = 2'd2;

  localparam logic [CAP_W-1:0] METHOD_CAP_RST = 12'd16;
  localparam logic [CAP_W-1:0] PATH_CAP_RST   = 12'd1024;
  localparam logic [CAP_W-1:0] QUERY_CAP_RST  = 12'd1024;

endpackage

[sv/http_request_line_splitter_unit.sv]
// ----------------------------------------------------------------------------
// http_request_line_splitter_unit
// Splits an HTTP request line, one byte per word, into method, path and
// query, echoing each byte with its field tag and giving a line status on
// the last byte.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+----------------------------------
//  in_     | input     | in_valid/in_ready | line_byte, line_end
//  out_    | output    | out_valid/out_ready | byte_out, field_tag, line_done,
//          |           |                   | line_status
//  cfg_    | input     | cfg_we            | cfg_index, cfg_wdata
//
//  One word per cycle sustained while out_ready stays high. A word is
//  captured in the input register, classified against the line state and
//  then registered into the result register, which drives the outputs.
//  Both registers move together whenever the result register is empty or
//  being taken, so a stalled consumer holds at most two words in flight.
//  Reset is synchronous and clears the line state, both valid flags and the
//  capacities to their defaults.
// ----------------------------------------------------------------------------
module http_request_line_splitter_unit #(
  parameter int COUNT_WIDTH = hrls_pkg::COUNT_WIDTH_D
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_line_byte,
  input  logic                           in_line_end,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte_out,
  output logic [1:0]                     out_field_tag,
  output logic                           out_line_done,
  output logic [1:0]                     out_line_status,
  input  logic                           cfg_we,
  input  logic [hrls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hrls_pkg::CAP_W-1:0]     cfg_wdata
);
  import hrls_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [1:0] {PH_METHOD, PH_PATH, PH_QUERY, PH_AFTER} phase_t;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  logic [CAP_W-1:0] method_cap_r, path_cap_r, query_cap_r;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_end_r;

  phase_t phase_r, phase_nxt;
  count_t mcnt_r, mcnt_nxt, pcnt_r, pcnt_nxt, qcnt_r, qcnt_nxt;
  logic   err_r, err_nxt, qseen_r, qseen_nxt;

  logic       out_vld_r;
  logic [7:0] out_byte_r;
  logic [1:0] out_tag_r, tag_nxt;
  logic       out_done_r;
  logic [1:0] out_stat_r, stat_nxt;

  logic adv;
  logic m_bad, p_bad, q_bad;
  logic err_line;

  assign adv      = !out_vld_r || out_ready;
  assign in_ready = !in_vld_r || adv;

  // A field is closed in error when it is empty or not below its capacity.
  assign m_bad = (mcnt_r == '0) || (CMP_W'(mcnt_r) >= CMP_W'(method_cap_r));
  assign p_bad = (pcnt_r == '0) || (CMP_W'(pcnt_r) >= CMP_W'(path_cap_r));
  assign q_bad = (qcnt_r == '0) || (CMP_W'(qcnt_r) >= CMP_W'(query_cap_r));

  always_comb begin
    phase_nxt = phase_r;
    mcnt_nxt  = mcnt_r;
    pcnt_nxt  = pcnt_r;
    qcnt_nxt  = qcnt_r;
    err_nxt   = err_r;
    qseen_nxt = qseen_r;
    tag_nxt   = TAG_SEP;
    stat_nxt  = STAT_OK;
    err_line  = 1'b0;
    case (phase_r)
      PH_METHOD: begin
        if (in_byte_r == CH_SPACE) begin
          if (m_bad) err_nxt = 1'b1;
          phase_nxt = PH_PATH;
        end else begin
          tag_nxt = TAG_METHOD;
          if (mcnt_r == CNT_MAX) err_nxt = 1'b1;
          else mcnt_nxt = mcnt_r + 1'b1;
        end
      end
      PH_PATH: begin
        if (in_byte_r == CH_SPACE) begin
          if (p_bad) err_nxt = 1'b1;
          phase_nxt = PH_AFTER;
        end else if (in_byte_r == CH_QMARK) begin
          if (p_bad) err_nxt = 1'b1;
          qseen_nxt = 1'b1;
          phase_nxt = PH_QUERY;
        end else begin
          tag_nxt = TAG_PATH;
          if (pcnt_r == CNT_MAX) err_nxt = 1'b1;
          else pcnt_nxt = pcnt_r + 1'b1;
        end
      end
      PH_QUERY: begin
        if (in_byte_r == CH_SPACE) begin
          if (q_bad) err_nxt = 1'b1;
          phase_nxt = PH_AFTER;
        end else begin
          tag_nxt = TAG_QUERY;
          if (qcnt_r == CNT_MAX) err_nxt = 1'b1;
          else qcnt_nxt = qcnt_r + 1'b1;
        end
      end
      default: ;
    endcase

    if (in_end_r) begin
      err_line = err_nxt || (phase_nxt != PH_AFTER);
      if (err_line)       stat_nxt = STAT_ERROR;
      else if (qseen_nxt) stat_nxt = STAT_OK_QUERY;
      else                stat_nxt = STAT_OK;
      // The line is finished, so the next word starts a fresh one.
      phase_nxt = PH_METHOD;
      mcnt_nxt  = '0;
      pcnt_nxt  = '0;
      qcnt_nxt  = '0;
      err_nxt   = 1'b0;
      qseen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_cap_r <= METHOD_CAP_RST;
      path_cap_r   <= PATH_CAP_RST;
      query_cap_r  <= QUERY_CAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_METHOD_CAP: method_cap_r <= cfg_wdata;
        CFG_PATH_CAP:   path_cap_r   <= cfg_wdata;
        CFG_QUERY_CAP:  query_cap_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      phase_r   <= PH_METHOD;
      mcnt_r    <= '0;
      pcnt_r    <= '0;
      qcnt_r    <= '0;
      err_r     <= 1'b0;
      qseen_r   <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= in_vld_r;
        if (in_vld_r) begin
          phase_r <= phase_nxt;
          mcnt_r  <= mcnt_nxt;
          pcnt_r  <= pcnt_nxt;
          qcnt_r  <= qcnt_nxt;
          err_r   <= err_nxt;
          qseen_r <= qseen_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_line_byte;
      in_end_r  <= in_line_end;
    end
    if (adv && in_vld_r) begin
      out_byte_r <= in_byte_r;
      out_tag_r  <= tag_nxt;
      out_done_r <= in_end_r;
      out_stat_r <= stat_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_byte_out    = out_byte_r;
  assign out_field_tag   = out_tag_r;
  assign out_line_done   = out_done_r;
  assign out_line_status = out_stat_r;

endmodule

[sv/hrls_checker.sv]
// ----------------------------------------------------------------------------
// hrls_checker
// Port-level checks on the request line splitter, bound to the top level.
// ----------------------------------------------------------------------------
module hrls_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte_out,
  input logic [1:0] out_field_tag,
  input logic       out_line_done,
  input logic [1:0] out_line_status
);
  import hrls_pkg::*;

  // Nothing comes out in the cycle after a reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Status stays at its idle code on words that do not end a line.
  a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_line_done) |-> (out_line_status == STAT_OK))
    else $error("status set on a word that does not end the line");

  // A line that ends inside a field never reached its second space.
  a_end_in_field: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_line_done &&
     (out_field_tag == TAG_METHOD || out_field_tag == TAG_PATH ||
      out_field_tag == TAG_QUERY))
    |-> (out_line_status == STAT_ERROR))
    else $error("line ended inside a field without error status");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
    (out_valid && $stable(out_byte_out) && $stable(out_field_tag) &&
     $stable(out_line_done) && $stable(out_line_status)))
    else $error("stalled result changed");

endmodule

bind http_request_line_splitter_unit hrls_checker u_hrls_checker (.*);
